FILE: rtl/mrt_pkg.sv
// shared types and constants for the multi-rate tick event timer
package mrt_pkg;

    // period register file geometry
    localparam int NUM_PERIODS = 6;
    localparam int PERIOD_W    = 16;
    localparam int IDX_W       = 3;
    localparam int MODE_W      = 3;
    localparam int COUNT_W     = 64;
    localparam int DELAY_W     = 32;

    // flag positions with side effects
    localparam logic [IDX_W-1:0] SEL_SECOND = 3'd4;
    localparam logic [IDX_W-1:0] SEL_MINUTE = 3'd5;
    localparam logic [IDX_W-1:0] SEL_LAST   = 3'd5;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FLAG  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POLL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    // divider step counter
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

    typedef logic [NUM_PERIODS-1:0][PERIOD_W-1:0] period_arr_t;

    // periods a, b, c, d, second, minute (index 0 at the low end)
    localparam period_arr_t PERIOD_RESET = {16'd60000, 16'd1000, 16'd100,
                                            16'd50, 16'd20, 16'd10};

    typedef enum logic {
        CAL_IDLE,
        CAL_DIV
    } cal_state_t;

    // recomputed residue handed from the calibrator to the core
    typedef struct packed {
        logic                valid;
        logic [IDX_W-1:0]    idx;
        logic [PERIOD_W-1:0] rem;
    } cal_result_t;

endpackage

FILE: rtl/mrt_cal.sv
// residue calibrator: recomputes phase mod period after a period register write
module mrt_cal
    import mrt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  period_arr_t      periods,
    input  logic [PERIOD_W-1:0] phase,
    output logic             busy,
    output cal_result_t      result
);

    cal_state_t               state_reg, state_next;
    logic [NUM_PERIODS-1:0]   dirty_reg, dirty_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [PERIOD_W-1:0]      divisor_reg, divisor_next;
    logic [PERIOD_W-1:0]      dividend_reg, dividend_next;
    logic [PERIOD_W-1:0]      rem_reg, rem_next;

    logic [IDX_W-1:0]         pick_idx;
    logic                     start;
    logic                     step;
    logic                     last_step;
    logic [PERIOD_W:0]        shifted;
    logic [PERIOD_W:0]        diff;
    logic [PERIOD_W-1:0]      rem_step;
    logic [NUM_PERIODS-1:0]   set_mask;
    logic [NUM_PERIODS-1:0]   clr_mask;

    // lowest pending register first
    always_comb
    begin
        pick_idx = '0;
        for (int k = NUM_PERIODS - 1; k >= 0; k--)
        begin
            if (dirty_reg[k])
            begin
                pick_idx = IDX_W'(k);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CAL_IDLE:
            begin
                if (dirty_reg != '0)
                begin
                    state_next = CAL_DIV;
                end
            end
            CAL_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = CAL_IDLE;
                end
            end
            default:
            begin
                state_next = CAL_IDLE;
            end
        endcase
    end

    // state decode
    always_comb
    begin
        start     = 1'b0;
        step      = 1'b0;
        last_step = 1'b0;
        case (state_reg)
            CAL_IDLE:
            begin
                start = (dirty_reg != '0);
            end
            CAL_DIV:
            begin
                step      = 1'b1;
                last_step = (cnt_reg == DIV_LAST);
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    // one restoring division step per cycle
    assign shifted  = {rem_reg, dividend_reg[PERIOD_W-1]};
    assign diff     = shifted - {1'b0, divisor_reg};
    assign rem_step = diff[PERIOD_W] ? shifted[PERIOD_W-1:0] : diff[PERIOD_W-1:0];

    // pending marks: a new write wins over the clear at job start
    always_comb
    begin
        set_mask = '0;
        clr_mask = '0;
        if (cfg_wr_en && (cfg_index <= SEL_LAST))
        begin
            set_mask = NUM_PERIODS'(1) << cfg_index;
        end
        if (start)
        begin
            clr_mask = NUM_PERIODS'(1) << pick_idx;
        end
        dirty_next = (dirty_reg & ~clr_mask) | set_mask;
    end

    // datapath next values
    always_comb
    begin
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        divisor_next  = divisor_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        if (start)
        begin
            cnt_next      = '0;
            idx_next      = pick_idx;
            divisor_next  = periods[pick_idx];
            dividend_next = phase;
            rem_next      = '0;
        end
        else if (step)
        begin
            cnt_next      = cnt_reg + 1'b1;
            dividend_next = {dividend_reg[PERIOD_W-2:0], 1'b0};
            rem_next      = rem_step;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CAL_IDLE;
            dirty_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        divisor_reg  <= divisor_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
    end

    assign busy         = (dirty_reg != '0) || (state_reg == CAL_DIV);
    assign result.valid = last_step;
    assign result.idx   = idx_reg;
    assign result.rem   = rem_step;

endmodule

FILE: rtl/mrt_core.sv
// timer state and the per-item update for tick, flag, delay and read operations
module mrt_core
    import mrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [MODE_W-1:0]   mode,
    input  logic [IDX_W-1:0]    period_sel,
    input  logic [DELAY_W-1:0]  delay_ms,
    input  period_arr_t         periods,
    input  cal_result_t         cal_res,
    output logic [PERIOD_W-1:0] phase,
    output logic                res_flag,
    output logic                res_done,
    output logic [COUNT_W-1:0]  res_ticks,
    output logic [COUNT_W-1:0]  res_seconds
);

    logic [PERIOD_W-1:0]    phase_reg, phase_next;
    logic [NUM_PERIODS-1:0] flags_reg, flags_next;
    logic [COUNT_W-1:0]     ticks_reg, ticks_next;
    logic [COUNT_W-1:0]     seconds_reg, seconds_next;
    logic                   armed_reg, armed_next;
    logic [COUNT_W-1:0]     origin_reg, origin_next;
    logic [DELAY_W-1:0]     length_reg, length_next;
    period_arr_t            resid_reg, resid_next;

    logic [PERIOD_W-1:0]    phase_inc;
    logic                   wrap;
    logic [NUM_PERIODS-1:0] hit;
    logic                   phase_zero;
    logic [COUNT_W-1:0]     elapsed;

    // period hits: the incremented residue of phase mod period reaches the period
    always_comb
    begin
        phase_inc = phase_reg + 1'b1;
        wrap      = (phase_inc == '0);
        for (int k = 0; k < NUM_PERIODS; k++)
        begin
            hit[k] = (periods[k] != '0) && !wrap &&
                     (({1'b0, resid_reg[k]} + 1'b1) == {1'b0, periods[k]});
        end
        phase_zero = wrap || hit[SEL_MINUTE];
    end

    assign elapsed = ticks_reg - origin_reg;

    // item update
    always_comb
    begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        ticks_next   = ticks_reg;
        seconds_next = seconds_reg;
        armed_next   = armed_reg;
        origin_next  = origin_reg;
        length_next  = length_reg;
        resid_next   = resid_reg;
        res_flag     = 1'b0;
        res_done     = 1'b0;
        if (take)
        begin
            case (mode)
                MODE_TICK:
                begin
                    ticks_next   = ticks_reg + 1'b1;
                    seconds_next = seconds_reg + COUNT_W'(hit[SEL_SECOND]);
                    flags_next   = flags_reg | hit;
                    phase_next   = phase_zero ? '0 : phase_inc;
                    for (int k = 0; k < NUM_PERIODS; k++)
                    begin
                        resid_next[k] = (phase_zero || hit[k]) ? '0
                                                               : resid_reg[k] + 1'b1;
                    end
                end
                MODE_FLAG:
                begin
                    if (period_sel <= SEL_LAST)
                    begin
                        res_flag               = flags_reg[period_sel];
                        flags_next[period_sel] = 1'b0;
                    end
                end
                MODE_POLL:
                begin
                    if (armed_reg)
                    begin
                        if (elapsed >= {{(COUNT_W-DELAY_W){1'b0}}, length_reg})
                        begin
                            res_done   = 1'b1;
                            armed_next = 1'b0;
                        end
                    end
                    else
                    begin
                        origin_next = ticks_reg;
                        length_next = delay_ms;
                        armed_next  = 1'b1;
                    end
                end
                MODE_CLEAR:
                begin
                    armed_next = 1'b0;
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
        // recalibrated residue, only while no items are taken
        if (cal_res.valid)
        begin
            resid_next[cal_res.idx] = cal_res.rem;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            flags_reg   <= '0;
            ticks_reg   <= '0;
            seconds_reg <= '0;
            armed_reg   <= 1'b0;
            origin_reg  <= '0;
            length_reg  <= '0;
            resid_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            flags_reg   <= flags_next;
            ticks_reg   <= ticks_next;
            seconds_reg <= seconds_next;
            armed_reg   <= armed_next;
            origin_reg  <= origin_next;
            length_reg  <= length_next;
            resid_reg   <= resid_next;
        end
    end

    assign phase       = phase_reg;
    assign res_ticks   = ticks_next;
    assign res_seconds = seconds_next;

endmodule

FILE: rtl/multi_rate_tick_event_timer.sv
// top level of the multi-rate tick event timer: period registers, handshake, result register
//
// The block takes one operation per cycle (tick, flag test-and-clear, delay poll, delay clear
// or read) and returns one result per operation, registered, in the next cycle; a waiting
// result does not block the next operation unless the output is stalled. Each period keeps a
// running residue of the phase, so a tick needs only an increment and compare per period.
// Writing a period register starts a recompute of that residue in a shared restoring divider,
// one quotient bit a cycle: the input is stalled until each written period register's residue
// is recomputed (back-to-back writes queue and add up); configuration writes are still taken.
module multi_rate_tick_event_timer
    import mrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [PERIOD_W-1:0] cfg_data,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [IDX_W-1:0]    period_sel,
    input  logic [DELAY_W-1:0]  delay_ms,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                flag_was_set,
    output logic                delay_done,
    output logic [COUNT_W-1:0]  tick_count,
    output logic [COUNT_W-1:0]  seconds_count
);

    period_arr_t         period_reg, period_next;
    logic                out_valid_reg, out_valid_next;
    logic                flag_reg;
    logic                done_reg;
    logic [COUNT_W-1:0]  ticks_out_reg;
    logic [COUNT_W-1:0]  seconds_out_reg;

    logic                take;
    logic                cal_busy;
    cal_result_t         cal_res;
    logic [PERIOD_W-1:0] phase;
    logic                res_flag;
    logic                res_done;
    logic [COUNT_W-1:0]  res_ticks;
    logic [COUNT_W-1:0]  res_seconds;

    // input transfer control
    assign in_stall = cal_busy || (out_valid_reg && out_stall);
    assign take     = in_valid && !in_stall;

    // period registers
    always_comb
    begin
        period_next = period_reg;
        if (cfg_wr_en && (cfg_index <= SEL_LAST))
        begin
            period_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else
        begin
            period_reg <= period_next;
        end
    end

    mrt_cal u_cal
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .periods   (period_reg),
        .phase     (phase),
        .busy      (cal_busy),
        .result    (cal_res)
    );

    mrt_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .mode        (mode),
        .period_sel  (period_sel),
        .delay_ms    (delay_ms),
        .periods     (period_reg),
        .cal_res     (cal_res),
        .phase       (phase),
        .res_flag    (res_flag),
        .res_done    (res_done),
        .res_ticks   (res_ticks),
        .res_seconds (res_seconds)
    );

    // result register
    assign out_valid_next = take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            flag_reg        <= res_flag;
            done_reg        <= res_done;
            ticks_out_reg   <= res_ticks;
            seconds_out_reg <= res_seconds;
        end
    end

    assign out_valid     = out_valid_reg;
    assign flag_was_set  = flag_reg;
    assign delay_done    = done_reg;
    assign tick_count    = ticks_out_reg;
    assign seconds_count = seconds_out_reg;

    // a period write holds off input until its residue is recomputed
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && (cfg_index <= SEL_LAST)) |=> in_stall)
        else $error("input not stalled after period register write");

    // every accepted item leaves a result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid)
        else $error("accepted item produced no result");

    // flag and delay results come from different operations
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(flag_was_set && delay_done))
        else $error("flag and delay results both set");

endmodule
